@@ src/vog_pkg.sv @@
package vog_pkg;

    localparam int COORD_W = 32;
    localparam int SIZE_REG_W = 7;
    localparam int RAD_REG_W = 3;
    localparam int RAD_W = 4;
    localparam int VOXEL_OUT_W = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 7'd64;
    localparam logic [COORD_W-1:0] INV_RES_RESET = 32'd327680;
    localparam logic [RAD_REG_W-1:0] RADIUS_RESET = 3'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_INV_RES  = 3'd3,
        CFG_SIZE_X   = 3'd4,
        CFG_SIZE_Y   = 3'd5,
        CFG_SIZE_Z   = 3'd6,
        CFG_RADIUS   = 3'd7
    } vog_cfg_idx_t;

    typedef enum logic {
        OP_MARK  = 1'b0,
        OP_QUERY = 1'b1
    } vog_op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_AXIS,
        ST_PLAN,
        ST_ROW_RD,
        ST_ROW_WR,
        ST_QUERY_BIT,
        ST_DONE
    } vog_state_t;

endpackage

@@ src/vog_in_if.sv @@
interface vog_in_if;
    import vog_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;

    modport source (output valid, operation, point_x, point_y, point_z, input ready);
    modport sink (input valid, operation, point_x, point_y, point_z, output ready);
endinterface

@@ src/vog_out_if.sv @@
interface vog_out_if;
    import vog_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   accepted;
    logic                   is_free;
    logic [VOXEL_OUT_W-1:0] voxel_x;
    logic [VOXEL_OUT_W-1:0] voxel_y;
    logic [VOXEL_OUT_W-1:0] voxel_z;

    modport source (output valid, accepted, is_free, voxel_x, voxel_y, voxel_z, input ready);
    modport sink (input valid, accepted, is_free, voxel_x, voxel_y, voxel_z, output ready);
endinterface

@@ src/vog_cfg_if.sv @@
interface vog_cfg_if;
    import vog_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ src/vog_ram.sv @@
module vog_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                                             clk,
    input  logic                                             we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     waddr,
    input  logic [WIDTH-1:0]                                 wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     raddr,
    output logic [WIDTH-1:0]                                 rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ src/vog_axis_unit.sv @@
// Shared index unit: one axis enters per cycle, and its result appears in the next cycle.
module vog_axis_unit #(
    parameter int SW = 7,
    parameter int IW = 6
) (
    input  logic                               clk,
    input  logic signed [vog_pkg::COORD_W-1:0] point,
    input  logic signed [vog_pkg::COORD_W-1:0] origin,
    input  logic [vog_pkg::COORD_W-1:0]        inv_res,
    input  logic [SW-1:0]                      size,
    output logic                               in_map,
    output logic [IW-1:0]                      clamp
);
    import vog_pkg::*;

    logic signed [COORD_W:0]     diff;
    logic [2*COORD_W-1:0]        prod;
    logic [2*COORD_W-1:0]        prod_reg;
    logic                        neg_reg;
    logic                        zinv_reg;
    logic [COORD_W-1:0]          idx;
    logic                        below;
    logic                        over;

    always_comb
    begin
        diff = (COORD_W+1)'(point) - (COORD_W+1)'(origin);
        prod = (2*COORD_W)'(diff[COORD_W-1:0]) * (2*COORD_W)'(inv_res);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        neg_reg  <= diff[COORD_W];
        zinv_reg <= (inv_res == '0);
    end

    always_comb
    begin
        idx   = prod_reg[2*COORD_W-1:COORD_W];
        below = neg_reg & ~zinv_reg;
        over  = ~neg_reg & (idx >= COORD_W'(size));
        if (neg_reg)
        begin
            clamp = '0;
        end
        else if (over)
        begin
            clamp = IW'(size - SW'(1));
        end
        else
        begin
            clamp = IW'(idx);
        end
        in_map = ~below & ~over;
    end
endmodule

@@ src/voxel_occupancy_grid_inflate_unit.sv @@
// Voxel occupancy grid with cube inflation.
// Three channels: "point" takes an operation and a Q16.16 point, "result"
// returns one item per point, and "cfg" writes the eight map registers by
// index. A cfg transfer is always taken, but registers are to be changed
// only while no point is in flight.
// Each point passes one axis at a time through the shared multiply and compare
// unit, then a planning step, and then either one memory read (query) or one
// read and one write per grid row of the cube (mark inside the map); a mark
// outside the map goes straight to the result. The
// occupancy memory holds one row of MAX_Z bits per (x, y) pair and has a
// single write and a single read port; its row sweep sets the pace.
// A new point is taken only when the sequencer is idle, while a finished
// result may still wait in the output register. If the receiver stalls, the
// next point completes and then waits until the output register is free.
// After reset the memory is cleared one row per cycle, all MAX_X*MAX_Y rows
// (4096 by default), and no point is taken until that pass ends.
module voxel_occupancy_grid_inflate_unit #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64,
    parameter int MAX_INFLATE = 7
) (
    input  logic         clk,
    input  logic         rst_n,
    vog_in_if.sink       point,
    vog_out_if.source    result,
    vog_cfg_if.sink      cfg
);
    import vog_pkg::*;

    localparam int MAXD  = (MAX_X > MAX_Y) ? ((MAX_X > MAX_Z) ? MAX_X : MAX_Z)
                                           : ((MAX_Y > MAX_Z) ? MAX_Y : MAX_Z);
    localparam int SW    = $clog2(MAXD + 1);
    localparam int IW    = (MAXD > 1) ? $clog2(MAXD) : 1;
    localparam int DW    = $clog2(MAXD + MAX_INFLATE + 1);
    localparam int XW    = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int YW    = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int ZW    = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int DEPTH = MAX_X * MAX_Y;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [COORD_W-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [COORD_W-1:0]        inv_res_reg;
    logic [SIZE_REG_W-1:0]     size_x_reg, size_y_reg, size_z_reg;
    logic [RAD_REG_W-1:0]      radius_reg;

    vog_state_t state_reg, state_next;
    logic [1:0]    axis_cnt_reg, axis_cnt_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          out_valid_reg, out_valid_next;

    logic                      op_reg;
    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic [XW-1:0]             cx_reg, hix_reg, x_cnt_reg;
    logic [YW-1:0]             cy_reg, loy_reg, hiy_reg, y_cnt_reg;
    logic [ZW-1:0]             cz_reg, loz_reg, hiz_reg;
    logic [2:0]                inside_reg;
    logic                      free_reg;
    logic                      out_acc_reg, out_free_reg;
    logic [VOXEL_OUT_W-1:0]    out_x_reg, out_y_reg, out_z_reg;

    logic [SW-1:0]             sx_eff, sy_eff, sz_eff, unit_size;
    logic [RAD_W-1:0]          r_eff;
    logic signed [COORD_W-1:0] unit_point, unit_origin;
    logic                      unit_inside;
    logic [IW-1:0]             unit_clamp;

    logic [DW-1:0] rd, cxd, cyd, czd, sumx, sumy, sumz, limx, limy, limz;
    logic [DW-1:0] lox_d, loy_d, loz_d, hix_d, hiy_d, hiz_d;

    logic [XW-1:0]    addr_x;
    logic [YW-1:0]    addr_y;
    logic [AW-1:0]    row_addr;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [MAX_Z-1:0] ram_wdata, ram_rdata, row_mask;
    logic             out_free_slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            inv_res_reg  <= INV_RES_RESET;
            size_x_reg   <= SIZE_RESET;
            size_y_reg   <= SIZE_RESET;
            size_z_reg   <= SIZE_RESET;
            radius_reg   <= RADIUS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_ORIGIN_X: origin_x_reg <= cfg.data;
                CFG_ORIGIN_Y: origin_y_reg <= cfg.data;
                CFG_ORIGIN_Z: origin_z_reg <= cfg.data;
                CFG_INV_RES:  inv_res_reg  <= cfg.data;
                CFG_SIZE_X:   size_x_reg   <= cfg.data[SIZE_REG_W-1:0];
                CFG_SIZE_Y:   size_y_reg   <= cfg.data[SIZE_REG_W-1:0];
                CFG_SIZE_Z:   size_z_reg   <= cfg.data[SIZE_REG_W-1:0];
                CFG_RADIUS:   radius_reg   <= cfg.data[RAD_REG_W-1:0];
                default:      radius_reg   <= radius_reg;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    always_comb
    begin
        sx_eff = (size_x_reg == '0) ? SW'(1) :
                 (32'(size_x_reg) > 32'(MAX_X)) ? SW'(MAX_X) : SW'(size_x_reg);
        sy_eff = (size_y_reg == '0) ? SW'(1) :
                 (32'(size_y_reg) > 32'(MAX_Y)) ? SW'(MAX_Y) : SW'(size_y_reg);
        sz_eff = (size_z_reg == '0) ? SW'(1) :
                 (32'(size_z_reg) > 32'(MAX_Z)) ? SW'(MAX_Z) : SW'(size_z_reg);
        r_eff  = (32'(radius_reg) > 32'(MAX_INFLATE)) ? RAD_W'(MAX_INFLATE)
                                                      : RAD_W'(radius_reg);
    end

    always_comb
    begin
        case (axis_cnt_reg)
            2'd0:
            begin
                unit_point  = px_reg;
                unit_origin = origin_x_reg;
            end
            2'd1:
            begin
                unit_point  = py_reg;
                unit_origin = origin_y_reg;
            end
            default:
            begin
                unit_point  = pz_reg;
                unit_origin = origin_z_reg;
            end
        endcase
        case (axis_cnt_reg)
            2'd1:    unit_size = sx_eff;
            2'd2:    unit_size = sy_eff;
            default: unit_size = sz_eff;
        endcase
    end

    vog_axis_unit #(
        .SW (SW),
        .IW (IW)
    ) u_axis (
        .clk     (clk),
        .point   (unit_point),
        .origin  (unit_origin),
        .inv_res (inv_res_reg),
        .size    (unit_size),
        .in_map  (unit_inside),
        .clamp   (unit_clamp)
    );

    always_comb
    begin
        rd    = DW'(r_eff);
        cxd   = DW'(cx_reg);
        cyd   = DW'(cy_reg);
        czd   = DW'(cz_reg);
        sumx  = cxd + rd;
        sumy  = cyd + rd;
        sumz  = czd + rd;
        limx  = DW'(sx_eff) - DW'(1);
        limy  = DW'(sy_eff) - DW'(1);
        limz  = DW'(sz_eff) - DW'(1);
        lox_d = (cxd >= rd) ? cxd - rd : '0;
        loy_d = (cyd >= rd) ? cyd - rd : '0;
        loz_d = (czd >= rd) ? czd - rd : '0;
        hix_d = (sumx > limx) ? limx : sumx;
        hiy_d = (sumy > limy) ? limy : sumy;
        hiz_d = (sumz > limz) ? limz : sumz;
    end

    always_comb
    begin
        row_mask = ({MAX_Z{1'b1}} << loz_reg) &
                   ({MAX_Z{1'b1}} >> (ZW'(MAX_Z - 1) - hiz_reg));
        addr_x   = (state_reg == ST_PLAN) ? cx_reg : x_cnt_reg;
        addr_y   = (state_reg == ST_PLAN) ? cy_reg : y_cnt_reg;
        row_addr = AW'(addr_x) * AW'(MAX_Y) + AW'(addr_y);
        ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_ROW_WR);
        ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : row_addr;
        ram_wdata = (state_reg == ST_CLEAR) ? '0 : (ram_rdata | row_mask);
    end

    vog_ram #(
        .WIDTH (MAX_Z),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (row_addr),
        .rdata (ram_rdata)
    );

    assign out_free_slot = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next     = state_reg;
        axis_cnt_next  = axis_cnt_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !result.ready;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (point.valid)
                begin
                    state_next    = ST_AXIS;
                    axis_cnt_next = '0;
                end
            end
            ST_AXIS:
            begin
                axis_cnt_next = axis_cnt_reg + 2'd1;
                if (axis_cnt_reg == 2'd3)
                begin
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN:
            begin
                if (op_reg == OP_QUERY)
                begin
                    state_next = ST_QUERY_BIT;
                end
                else if (&inside_reg)
                begin
                    state_next = ST_ROW_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ROW_RD:
            begin
                state_next = ST_ROW_WR;
            end
            ST_ROW_WR:
            begin
                if ((y_cnt_reg == hiy_reg) && (x_cnt_reg == hix_reg))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ROW_RD;
                end
            end
            ST_QUERY_BIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free_slot)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            axis_cnt_reg  <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_cnt_reg  <= axis_cnt_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && point.valid)
        begin
            op_reg <= point.operation;
            px_reg <= point.point_x;
            py_reg <= point.point_y;
            pz_reg <= point.point_z;
        end
        if (state_reg == ST_AXIS)
        begin
            case (axis_cnt_reg)
                2'd1:
                begin
                    cx_reg        <= XW'(unit_clamp);
                    inside_reg[0] <= unit_inside;
                end
                2'd2:
                begin
                    cy_reg        <= YW'(unit_clamp);
                    inside_reg[1] <= unit_inside;
                end
                2'd3:
                begin
                    cz_reg        <= ZW'(unit_clamp);
                    inside_reg[2] <= unit_inside;
                end
                default:
                begin
                    inside_reg <= inside_reg;
                end
            endcase
        end
        if (state_reg == ST_PLAN)
        begin
            hix_reg   <= XW'(hix_d);
            loy_reg   <= YW'(loy_d);
            hiy_reg   <= YW'(hiy_d);
            loz_reg   <= ZW'(loz_d);
            hiz_reg   <= ZW'(hiz_d);
            x_cnt_reg <= XW'(lox_d);
            y_cnt_reg <= YW'(loy_d);
            free_reg  <= 1'b0;
        end
        if (state_reg == ST_ROW_WR)
        begin
            if (y_cnt_reg == hiy_reg)
            begin
                y_cnt_reg <= loy_reg;
                x_cnt_reg <= x_cnt_reg + XW'(1);
            end
            else
            begin
                y_cnt_reg <= y_cnt_reg + YW'(1);
            end
        end
        if (state_reg == ST_QUERY_BIT)
        begin
            free_reg <= ~ram_rdata[cz_reg];
        end
        if (state_reg == ST_DONE && out_free_slot)
        begin
            out_acc_reg  <= (op_reg == OP_QUERY) ? 1'b1 : (&inside_reg);
            out_free_reg <= free_reg;
            out_x_reg    <= VOXEL_OUT_W'(cx_reg);
            out_y_reg    <= VOXEL_OUT_W'(cy_reg);
            out_z_reg    <= VOXEL_OUT_W'(cz_reg);
        end
    end

    assign point.ready     = (state_reg == ST_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.accepted = out_acc_reg;
    assign result.is_free  = out_free_reg;
    assign result.voxel_x  = out_x_reg;
    assign result.voxel_y  = out_y_reg;
    assign result.voxel_z  = out_z_reg;
endmodule

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vog_pkg::*;

    localparam int GRID_X = 64;
    localparam int GRID_Y = 64;
    localparam int GRID_Z = 64;
    localparam int INFLATE_MAX = 7;
    localparam int PHASES = 9;
    localparam int PHASE_ITEMS [PHASES] = '{150, 150, 80, 150, 80, 80, 300, 300, 250};

    typedef struct packed {
        logic                   accepted;
        logic                   is_free;
        logic [VOXEL_OUT_W-1:0] voxel_x;
        logic [VOXEL_OUT_W-1:0] voxel_y;
        logic [VOXEL_OUT_W-1:0] voxel_z;
    } voxel_report_t;

    class occupancy_tracker;
        logic signed [COORD_W-1:0] origin [3];
        logic [COORD_W-1:0]        inv_res;
        logic [SIZE_REG_W-1:0]     size_reg [3];
        logic [RAD_REG_W-1:0]      radius;
        bit [GRID_Z-1:0]           occupied [GRID_X*GRID_Y];
        voxel_report_t             reports [$];
        int                        failures;

        function new();
            origin = '{default: '0};
            inv_res = INV_RES_RESET;
            size_reg = '{default: SIZE_RESET};
            radius = RADIUS_RESET;
            failures = 0;
        endfunction

        function void write_reg(vog_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ORIGIN_X: origin[0] = data;
                CFG_ORIGIN_Y: origin[1] = data;
                CFG_ORIGIN_Z: origin[2] = data;
                CFG_INV_RES:  inv_res = data;
                CFG_SIZE_X:   size_reg[0] = data[SIZE_REG_W-1:0];
                CFG_SIZE_Y:   size_reg[1] = data[SIZE_REG_W-1:0];
                CFG_SIZE_Z:   size_reg[2] = data[SIZE_REG_W-1:0];
                CFG_RADIUS:   radius = data[RAD_REG_W-1:0];
                default:      ;
            endcase
        endfunction

        function int axis_size(int a);
            int s;
            int lim;
            s = int'(size_reg[a]);
            lim = (a == 0) ? GRID_X : (a == 1) ? GRID_Y : GRID_Z;
            if (s == 0)
                return 1;
            return (s > lim) ? lim : s;
        endfunction

        // Floor of (point - origin) * inverse resolution; -1 stands for below the map.
        function longint voxel_index(int a, logic [COORD_W-1:0] pt);
            longint d;
            logic [65:0] prod;
            d = longint'(signed'(pt)) - longint'(origin[a]);
            if (d < 0)
                return (inv_res == '0) ? 0 : -1;
            prod = 66'(d) * 66'(inv_res);
            return longint'(prod[65:32]);
        endfunction

        function void predict_point(vog_op_t op, logic [COORD_W-1:0] px,
                                    logic [COORD_W-1:0] py, logic [COORD_W-1:0] pz);
            logic [COORD_W-1:0] pts [3];
            longint idx [3];
            int lim [3];
            int clamped [3];
            bit in_map;
            int r;
            int tx;
            int ty;
            int tz;
            voxel_report_t rep;
            pts[0] = px;
            pts[1] = py;
            pts[2] = pz;
            in_map = 1'b1;
            for (int a = 0; a < 3; a++)
            begin
                idx[a] = voxel_index(a, pts[a]);
                lim[a] = axis_size(a);
                if (idx[a] < 0)
                begin
                    clamped[a] = 0;
                    in_map = 1'b0;
                end
                else if (idx[a] >= lim[a])
                begin
                    clamped[a] = lim[a] - 1;
                    in_map = 1'b0;
                end
                else
                    clamped[a] = int'(idx[a]);
            end
            rep.accepted = 1'b1;
            rep.is_free = 1'b0;
            rep.voxel_x = VOXEL_OUT_W'(clamped[0]);
            rep.voxel_y = VOXEL_OUT_W'(clamped[1]);
            rep.voxel_z = VOXEL_OUT_W'(clamped[2]);
            if (op == OP_MARK)
            begin
                rep.accepted = in_map;
                if (in_map)
                begin
                    r = int'(radius);
                    if (r > INFLATE_MAX)
                        r = INFLATE_MAX;
                    for (int i = -r; i <= r; i++)
                    begin
                        tx = clamped[0] + i;
                        if (tx < 0 || tx >= lim[0])
                            continue;
                        for (int j = -r; j <= r; j++)
                        begin
                            ty = clamped[1] + j;
                            if (ty < 0 || ty >= lim[1])
                                continue;
                            for (int k = -r; k <= r; k++)
                            begin
                                tz = clamped[2] + k;
                                if (tz < 0 || tz >= lim[2])
                                    continue;
                                occupied[tx * GRID_Y + ty][tz] = 1'b1;
                            end
                        end
                    end
                end
            end
            else
                rep.is_free = !occupied[clamped[0] * GRID_Y + clamped[1]][clamped[2]];
            reports.push_back(rep);
        endfunction

        function void check_result(voxel_report_t got);
            voxel_report_t want;
            if (reports.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display({"tb: result transfer with no point pending: ",
                              "acc %0b free %0b voxel %0d,%0d,%0d"},
                             got.accepted, got.is_free, got.voxel_x, got.voxel_y,
                             got.voxel_z);
                return;
            end
            want = reports.pop_front();
            if (got.accepted !== want.accepted || got.is_free !== want.is_free ||
                got.voxel_x !== want.voxel_x || got.voxel_y !== want.voxel_y ||
                got.voxel_z !== want.voxel_z)
            begin
                failures++;
                if (failures <= 10)
                    $display({"tb: mismatch: exp acc %0b free %0b voxel %0d,%0d,%0d, ",
                              "got acc %0b free %0b voxel %0d,%0d,%0d"},
                             want.accepted, want.is_free, want.voxel_x, want.voxel_y,
                             want.voxel_z, got.accepted, got.is_free, got.voxel_x,
                             got.voxel_y, got.voxel_z);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    vog_in_if  point_if ();
    vog_out_if result_if ();
    vog_cfg_if cfg_if ();

    voxel_occupancy_grid_inflate_unit #(
        .MAX_X       (GRID_X),
        .MAX_Y       (GRID_Y),
        .MAX_Z       (GRID_Z),
        .MAX_INFLATE (INFLATE_MAX)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    occupancy_tracker tracker;
    voxel_report_t    observed;
    longint           last_mark [3];
    int               send_idle_pct;
    int               stall_pct;
    int               hold_left;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            observed.accepted = result_if.accepted;
            observed.is_free = result_if.is_free;
            observed.voxel_x = result_if.voxel_x;
            observed.voxel_y = result_if.voxel_y;
            observed.voxel_z = result_if.voxel_z;
            tracker.check_result(observed);
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_if.ready <= 1'b0;
        end
        else
            result_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [COORD_W-1:0] at_voxel(int i);
        return COORD_W'(i * 13108);
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(int axis, bit near);
        longint v;
        longint num;
        int r;
        int off;
        if ($urandom_range(9) == 0)
        begin
            case ($urandom_range(2))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                default: return $urandom;
            endcase
        end
        if (tracker.inv_res == '0)
            return $urandom;
        r = int'(tracker.radius);
        off = int'($urandom_range(2 * r + 2)) - (r + 1);
        if (near)
            v = last_mark[axis] + off;
        else
            v = longint'($urandom_range(tracker.axis_size(axis) + 3)) - 2;
        num = (v <<< 32) + longint'($urandom);
        return COORD_W'(longint'(tracker.origin[axis]) + num / longint'(tracker.inv_res));
    endfunction

    task automatic send_point(vog_op_t op, logic [COORD_W-1:0] px,
                              logic [COORD_W-1:0] py, logic [COORD_W-1:0] pz);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (send_idle_pct > 0 && $urandom_range(19) == 0)
            gap += $urandom_range(40);
        if (gap > 0)
        begin
            point_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_if.valid <= 1'b1;
        point_if.operation <= op;
        point_if.point_x <= px;
        point_if.point_y <= py;
        point_if.point_z <= pz;
        do
            @(posedge clk);
        while (!point_if.ready);
        tracker.predict_point(op, px, py, pz);
    endtask

    task automatic send_random(int count);
        vog_op_t op;
        bit near;
        longint idx;
        logic [COORD_W-1:0] c [3];
        for (int n = 0; n < count; n++)
        begin
            op = ($urandom_range(99) < 40) ? OP_MARK : OP_QUERY;
            near = (op == OP_QUERY) ? ($urandom_range(1) == 1) : ($urandom_range(4) == 0);
            for (int a = 0; a < 3; a++)
                c[a] = pick_coord(a, near);
            if (op == OP_MARK)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    idx = tracker.voxel_index(a, c[a]);
                    if (idx >= 0 && idx < tracker.axis_size(a))
                        last_mark[a] = idx;
                end
            end
            send_point(op, c[0], c[1], c[2]);
        end
        point_if.valid <= 1'b0;
    endtask

    task automatic write_reg(vog_cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        tracker.write_reg(idx, data);
    endtask

    task automatic wait_drained();
        while (tracker.reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_setting(int phase);
        case (phase)
            1:
            begin
                write_reg(CFG_ORIGIN_X, 32'hFFFD_0000);
                write_reg(CFG_ORIGIN_Y, 32'hFFFE_8000);
                write_reg(CFG_ORIGIN_Z, 32'h0000_4000);
                write_reg(CFG_INV_RES, 32'd131072);
                write_reg(CFG_RADIUS, 32'd0);
            end
            2:
            begin
                write_reg(CFG_ORIGIN_X, 32'd0);
                write_reg(CFG_ORIGIN_Y, 32'd0);
                write_reg(CFG_ORIGIN_Z, 32'd0);
                write_reg(CFG_INV_RES, 32'd327680);
                write_reg(CFG_SIZE_X, 32'd0);
                write_reg(CFG_SIZE_Y, 32'd127);
                write_reg(CFG_SIZE_Z, 32'd17);
                write_reg(CFG_RADIUS, 32'd7);
            end
            3:
            begin
                write_reg(CFG_SIZE_X, 32'd64);
                write_reg(CFG_SIZE_Y, 32'd64);
                write_reg(CFG_SIZE_Z, 32'd64);
                write_reg(CFG_RADIUS, 32'd2);
                write_reg(CFG_INV_RES, 32'hFFFF_FFFF);
                write_reg(CFG_ORIGIN_X, 32'h7FFF_FFC0);
                write_reg(CFG_ORIGIN_Y, 32'h8000_0000);
                write_reg(CFG_ORIGIN_Z, 32'hFFFF_FF9C);
            end
            4:
            begin
                write_reg(CFG_INV_RES, 32'd0);
                write_reg(CFG_RADIUS, 32'd3);
                write_reg(CFG_SIZE_X, 32'd40);
                write_reg(CFG_SIZE_Y, 32'd64);
                write_reg(CFG_SIZE_Z, 32'd8);
            end
            5:
            begin
                write_reg(CFG_INV_RES, 32'd1);
                write_reg(CFG_ORIGIN_X, 32'h8000_0000);
                write_reg(CFG_ORIGIN_Y, 32'd0);
                write_reg(CFG_ORIGIN_Z, 32'h7FFF_FFFF);
                write_reg(CFG_SIZE_X, 32'd2);
                write_reg(CFG_SIZE_Y, 32'd2);
                write_reg(CFG_SIZE_Z, 32'd2);
                write_reg(CFG_RADIUS, 32'd1);
            end
            6:
            begin
                write_reg(CFG_INV_RES, 32'd688128);
                write_reg(CFG_ORIGIN_X, 32'd65536);
                write_reg(CFG_ORIGIN_Y, 32'd65536);
                write_reg(CFG_ORIGIN_Z, 32'd65536);
                write_reg(CFG_SIZE_X, 32'd64);
                write_reg(CFG_SIZE_Y, 32'd33);
                write_reg(CFG_SIZE_Z, 32'd64);
            end
            7:
            begin
                write_reg(CFG_INV_RES, 32'd212992);
                write_reg(CFG_ORIGIN_X, 32'(int'($urandom_range(1 << 21)) - (1 << 20)));
                write_reg(CFG_ORIGIN_Y, 32'(int'($urandom_range(1 << 21)) - (1 << 20)));
                write_reg(CFG_ORIGIN_Z, 32'(int'($urandom_range(1 << 21)) - (1 << 20)));
                write_reg(CFG_RADIUS, 32'd2);
                write_reg(CFG_SIZE_Y, 32'd64);
            end
            default:
            begin
                write_reg(CFG_INV_RES, 32'd1310720);
                write_reg(CFG_RADIUS, 32'd0);
                write_reg(CFG_ORIGIN_X, 32'hFFF6_0000);
                write_reg(CFG_ORIGIN_Y, 32'hFFF6_0000);
                write_reg(CFG_ORIGIN_Z, 32'hFFF6_0000);
            end
        endcase
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 45;
                stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct = 45;
            end
            default:
            begin
                send_idle_pct = 24;
                stall_pct = 24;
            end
        endcase
    endtask

    task automatic run_directed();
        send_point(OP_MARK, at_voxel(0), at_voxel(0), at_voxel(0));
        send_point(OP_QUERY, at_voxel(0), at_voxel(0), at_voxel(0));
        send_point(OP_QUERY, at_voxel(1), at_voxel(1), at_voxel(1));
        send_point(OP_QUERY, at_voxel(2), at_voxel(0), at_voxel(0));
        send_point(OP_MARK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(OP_MARK, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        // The last point below the upper bound of the map, and the first one past it.
        send_point(OP_MARK, 32'd838860, 32'd838860, 32'd838860);
        send_point(OP_MARK, 32'd838861, at_voxel(5), at_voxel(5));
        send_point(OP_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(OP_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, at_voxel(10));
        send_point(OP_MARK, 32'hFFFF_FFFF, at_voxel(3), at_voxel(3));
        send_point(OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(OP_MARK, at_voxel(30), at_voxel(30), at_voxel(30));
        send_point(OP_QUERY, at_voxel(31), at_voxel(29), at_voxel(30));
        send_point(OP_QUERY, at_voxel(32), at_voxel(30), at_voxel(30));
        send_point(OP_QUERY, at_voxel(30), at_voxel(30), at_voxel(28));
        send_point(OP_MARK, at_voxel(62), at_voxel(1), at_voxel(40));
        send_point(OP_QUERY, at_voxel(63), at_voxel(0), at_voxel(41));
        point_if.valid <= 1'b0;
    endtask

    initial
    begin
        #8_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        tracker = new();
        last_mark = '{default: 0};
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        rst_n = 1'b0;
        point_if.valid = 1'b0;
        point_if.operation = OP_MARK;
        point_if.point_x = '0;
        point_if.point_y = '0;
        point_if.point_z = '0;
        result_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_ORIGIN_X;
        cfg_if.data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_drained();
                apply_setting(phase);
            end
            set_idling(phase % 4);
            if (phase == 4 || phase == 7)
            begin
                // A long hold-off on the result side, so that the unit fills up and
                // refuses further point transfers for a while.
                @(negedge clk);
                hold_left = 300;
                @(posedge clk);
            end
            send_random(PHASE_ITEMS[phase]);
        end
        wait_drained();
        repeat (64) @(posedge clk);
        if (tracker.failures == 0 && tracker.reports.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
